[rtl/core/iso2sj_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO-2022-JP to Shift-JIS converter package
// Character codes, mode codes, state and result types, JIS pair mapping.
// ----------------------------------------------------------------------------
package iso2sj_pkg;

  localparam logic [7:0] ESC_CHAR     = 8'h1B;
  localparam logic [7:0] LPAREN_CHAR  = 8'h28;
  localparam logic [7:0] RPAREN_CHAR  = 8'h29;
  localparam logic [7:0] DOLLAR_CHAR  = 8'h24;
  localparam logic [7:0] AT_CHAR      = 8'h40;
  localparam logic [7:0] B_CHAR       = 8'h42;
  localparam logic [7:0] I_CHAR       = 8'h49;
  localparam logic [7:0] J_CHAR       = 8'h4A;
  localparam logic [7:0] KANA_OFFSET  = 8'h80;
  localparam logic [7:0] JIS_LOW      = 8'h21;
  localparam logic [7:0] JIS_HIGH     = 8'h7E;

  localparam logic [1:0] MODE_ASCII   = 2'd0;
  localparam logic [1:0] MODE_KANA    = 2'd1;
  localparam logic [1:0] MODE_DOUBLE  = 2'd2;

  localparam logic [1:0] HELD_NONE    = 2'd0;
  localparam logic [1:0] HELD_ONE     = 2'd1;
  localparam logic [1:0] HELD_TWO     = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] held_cnt;
    logic [7:0] h0;
    logic [7:0] h1;
    logic       pair;
  } cvt_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       bad;
  } res_t;

  typedef struct packed {
    logic [7:0] data;
    logic       bad;
    logic       last;
  } obuf_ent_t;

  typedef struct packed {
    logic       bad;
    logic [7:0] hi;
    logic [7:0] lo;
  } pair_t;

  function automatic pair_t jis_pair(input logic [7:0] hi, input logic [7:0] lo);
    pair_t      p;
    logic [8:0] hsum;
    logic [7:0] hi_o;
    logic [7:0] lo_o;
    hsum = {1'b0, hi} + 9'd1;
    hi_o = hsum[8:1] + 8'h70;
    if (hi_o >= 8'hA0) begin
      hi_o = hi_o + 8'h40;
    end
    if (hi[0]) begin
      lo_o = lo + ((lo >= 8'h60) ? 8'h20 : 8'h1F);
    end else begin
      lo_o = lo + 8'h7E;
    end
    p.bad = (hi < JIS_LOW) || (hi > JIS_HIGH) || (lo < JIS_LOW) || (lo > JIS_HIGH);
    p.hi  = p.bad ? 8'h00 : hi_o;
    p.lo  = p.bad ? 8'h00 : lo_o;
    return p;
  endfunction

endpackage

[rtl/core/iso2sj_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO-2022-JP to Shift-JIS decode step
// Escape matching, mode handling and pair mapping for one input item.
// ----------------------------------------------------------------------------
module iso2sj_decode
  import iso2sj_pkg::*;
(
  input  cvt_state_t       st,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output cvt_state_t       st_nxt,
  output res_t [2:0]       res,
  output logic [1:0]       res_cnt
);

  logic       hc1, hc2, intro, match, dbl;
  logic [1:0] pre_n;
  logic       p_mid, hold_b, use_b;
  logic [1:0] new_mode;
  logic [7:0] slot [3];
  logic [2:0] slot_v;
  logic       p_run;
  logic [7:0] pend;
  logic [2:0] idx;
  res_t       tmp [6];
  pair_t      pr;

  assign hc1   = (st.held_cnt == HELD_ONE);
  assign hc2   = (st.held_cnt == HELD_TWO);
  assign dbl   = (st.mode == MODE_DOUBLE);
  assign intro = (in_byte == LPAREN_CHAR) || (in_byte == DOLLAR_CHAR) ||
                 (in_byte == RPAREN_CHAR);

  always_comb begin
    match    = 1'b0;
    new_mode = st.mode;
    if (hc2) begin
      if (st.h1 == LPAREN_CHAR && (in_byte == B_CHAR || in_byte == J_CHAR)) begin
        match    = 1'b1;
        new_mode = MODE_ASCII;
      end else if (st.h1 == LPAREN_CHAR && in_byte == I_CHAR) begin
        match    = 1'b1;
        new_mode = MODE_KANA;
      end else if (st.h1 == DOLLAR_CHAR && (in_byte == AT_CHAR || in_byte == B_CHAR)) begin
        match    = 1'b1;
        new_mode = MODE_DOUBLE;
      end else if (st.h1 == RPAREN_CHAR && in_byte == I_CHAR) begin
        match    = 1'b1;
        new_mode = MODE_ASCII;
      end
    end
  end

  always_comb begin
    if (hc1 && (!intro || in_last)) begin
      pre_n = 2'd1;
    end else if (hc2 && !match) begin
      pre_n = 2'd2;
    end else begin
      pre_n = 2'd0;
    end
  end

  assign p_mid  = st.pair ^ (dbl & pre_n[0]);
  assign hold_b = (in_byte == ESC_CHAR) && !p_mid;
  assign use_b  = !(hc1 && intro && !in_last) && !match && !(hold_b && !in_last);

  always_comb begin
    slot[0]   = (pre_n != 2'd0) ? st.h0 : in_byte;
    slot[1]   = (pre_n == 2'd2) ? st.h1 : in_byte;
    slot[2]   = in_byte;
    slot_v[0] = (pre_n != 2'd0) || use_b;
    slot_v[1] = (pre_n == 2'd2) || ((pre_n == 2'd1) && use_b);
    slot_v[2] = (pre_n == 2'd2) && use_b;
  end

  always_comb begin
    p_run = st.pair;
    pend  = st.h0;
    idx   = 3'd0;
    pr    = '0;
    for (int i = 0; i < 6; i++) begin
      tmp[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      if (slot_v[i]) begin
        if (dbl) begin
          if (p_run) begin
            pr               = jis_pair(pend, slot[i]);
            tmp[idx]         = '{data: pr.hi, bad: pr.bad};
            tmp[idx + 3'd1]  = '{data: pr.lo, bad: pr.bad};
            idx              = idx + 3'd2;
            p_run            = 1'b0;
          end else begin
            pend  = slot[i];
            p_run = 1'b1;
          end
        end else begin
          tmp[idx] = '{data: (st.mode == MODE_KANA) ? slot[i] + KANA_OFFSET : slot[i],
                       bad: 1'b0};
          idx      = idx + 3'd1;
        end
      end
    end
  end

  assign res[0]  = tmp[0];
  assign res[1]  = tmp[1];
  assign res[2]  = tmp[2];
  assign res_cnt = (idx > 3'd3) ? 2'd3 : idx[1:0];

  always_comb begin
    st_nxt = st;
    if (in_last) begin
      st_nxt.mode     = MODE_ASCII;
      st_nxt.held_cnt = HELD_NONE;
      st_nxt.pair     = 1'b0;
    end else begin
      st_nxt.mode = new_mode;
      st_nxt.pair = p_run;
      st_nxt.h0   = hold_b ? in_byte : pend;
      if (hc1 && intro) begin
        st_nxt.held_cnt = HELD_TWO;
        st_nxt.h1       = in_byte;
      end else if (hold_b) begin
        st_nxt.held_cnt = HELD_ONE;
      end else begin
        st_nxt.held_cnt = HELD_NONE;
      end
    end
  end

endmodule

[rtl/core/iso2sj_obuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO-2022-JP to Shift-JIS result buffer
// Three-entry result register, drained one item per cycle while out_tready is high.
// ----------------------------------------------------------------------------
module iso2sj_obuf
  import iso2sj_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t [2:0] res,
  input  logic [1:0] res_cnt,
  output logic       can_load,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tuser,
  output logic       out_tlast
);

  obuf_ent_t ent_r [3];
  obuf_ent_t ent_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop        = (cnt_r != 2'd0) && out_tready;
  assign can_load   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = ent_r[0].data;
  assign out_tuser  = ent_r[0].bad;
  assign out_tlast  = ent_r[0].last;

  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < 3; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    if (load) begin
      cnt_nxt = res_cnt;
      for (int i = 0; i < 3; i++) begin
        ent_nxt[i] = '{data: res[i].data, bad: res[i].bad,
                       last: (2'(i) == res_cnt - 2'd1)};
      end
    end else if (pop) begin
      cnt_nxt    = cnt_r - 2'd1;
      ent_nxt[0] = ent_r[1];
      ent_nxt[1] = ent_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

endmodule

[rtl/core/iso2022jp_to_shift_jis_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO-2022-JP to Shift-JIS converter
// Strips escapes, shifts katakana and maps JIS X 0208 pairs to Shift-JIS.
// ----------------------------------------------------------------------------
// channel | dir | tdata            | tuser     | tlast
// in_     | in  | [7:0] in_byte    | -         | in_last
// out_    | out | [7:0] out_byte   | bad_pair  | out_last
//
// One input item is decoded in the cycle it is accepted; its 0 to 3 results
// land in a three-entry result register and leave one per cycle while
// out_tready is high. An item giving at most one result sustains one item per
// cycle with out_tready high; more results stall the input while the buffer drains.
// Synchronous active-low reset returns to ASCII mode with nothing held.
// ----------------------------------------------------------------------------
module iso2022jp_to_shift_jis_top
  import iso2sj_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] bad_pair
  output logic       out_tlast
);

  logic [1:0] mode_r, held_cnt_r;
  logic       pair_r;
  logic [7:0] h0_r, h1_r;
  cvt_state_t st, st_nxt;
  res_t [2:0] res;
  logic [1:0] res_cnt;
  logic       can_load, in_fire;

  assign st        = '{mode: mode_r, held_cnt: held_cnt_r, h0: h0_r, h1: h1_r, pair: pair_r};
  assign in_tready = can_load;
  assign in_fire   = in_tvalid && can_load;

  iso2sj_decode u_decode (
    .st      (st),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .st_nxt  (st_nxt),
    .res     (res),
    .res_cnt (res_cnt)
  );

  iso2sj_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .res        (res),
    .res_cnt    (res_cnt),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_ASCII;
      held_cnt_r <= HELD_NONE;
      pair_r     <= 1'b0;
    end else if (in_fire) begin
      mode_r     <= st_nxt.mode;
      held_cnt_r <= st_nxt.held_cnt;
      pair_r     <= st_nxt.pair;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      h0_r <= st_nxt.h0;
      h1_r <= st_nxt.h1;
    end
  end

`ifndef SYNTHESIS
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> mode_r == MODE_ASCII && held_cnt_r == HELD_NONE && !pair_r)
    else $error("state not cleared after last item");

  a_pair_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    !(pair_r && held_cnt_r != HELD_NONE))
    else $error("escape held while a pair byte is pending");

  a_pair_mode: assert property (@(posedge clk) disable iff (!rst_n)
    pair_r |-> mode_r == MODE_DOUBLE)
    else $error("pair byte pending outside double-byte mode");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'h00)
    else $error("bad pair item carries non-zero data");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO-2022-JP to Shift-JIS converter testbench
// Streams directed and random ISO-2022-JP bytes into the converter, predicts
// the Shift-JIS bytes of every accepted item and compares each output item,
// field by field, with the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import iso2sj_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 320;
  localparam int QUIET_TAIL   = 60;
  localparam int EXP_DEPTH    = 4096;

  typedef struct packed {
    logic [7:0] data;
    logic       bad;
    logic       last;
  } sjis_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tuser;          // [0] bad_pair
  logic       out_tlast;

  int         errors = 0;
  int         items_sent = 0;
  int         idle_cycles = 0;
  int         ready_hold = 0;
  bit         quiet = 1'b0;

  logic [1:0] sj_mode = MODE_ASCII;
  logic [1:0] sj_held = HELD_NONE;
  logic [7:0] sj_h0 = 8'h00;
  logic [7:0] sj_h1 = 8'h00;
  logic       sj_pair = 1'b0;
  sjis_byte_t step_bytes[3];
  int         step_n;
  sjis_byte_t exp_buf[EXP_DEPTH];
  int         exp_wr = 0;
  int         exp_rd = 0;

  iso2022jp_to_shift_jis_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  task automatic put_sjis(input logic [7:0] d, input logic bad);
    if (step_n < 3) begin
      step_bytes[step_n] = '{data: d, bad: bad, last: 1'b0};
      step_n++;
    end
  endtask

  task automatic put_jis_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [8:0] hi_sum;
    logic [7:0] hi_o;
    logic [7:0] lo_o;
    if (hi < JIS_LOW || hi > JIS_HIGH || lo < JIS_LOW || lo > JIS_HIGH) begin
      put_sjis(8'h00, 1'b1);
      put_sjis(8'h00, 1'b1);
    end else begin
      if (hi[0]) begin
        lo_o = lo + ((lo >= 8'h60) ? 8'h20 : 8'h1F);
      end else begin
        lo_o = lo + 8'h7E;
      end
      hi_sum = ({1'b0, hi} + 9'd1) >> 1;
      hi_o = hi_sum[7:0] + 8'h70;
      if (hi_o >= 8'hA0) begin
        hi_o = hi_o + 8'h40;
      end
      put_sjis(hi_o, 1'b0);
      put_sjis(lo_o, 1'b0);
    end
  endtask

  task automatic convert_plain(input logic [7:0] b);
    if (sj_mode == MODE_DOUBLE) begin
      if (sj_pair) begin
        sj_pair = 1'b0;
        put_jis_pair(sj_h0, b);
      end else begin
        sj_h0   = b;
        sj_pair = 1'b1;
      end
    end else if (sj_mode == MODE_KANA) begin
      put_sjis(b + KANA_OFFSET, 1'b0);
    end else begin
      put_sjis(b, 1'b0);
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (!sj_pair && b == ESC_CHAR) begin
      sj_h0   = b;
      sj_held = HELD_ONE;
    end else begin
      convert_plain(b);
    end
  endtask

  task automatic predict_sjis(input logic [7:0] b, input logic last);
    logic [7:0] p0;
    logic [7:0] p1;
    logic [1:0] cnt;
    step_n = 0;
    p0 = sj_h0;
    p1 = sj_h1;
    if (sj_held == HELD_ONE) begin
      if (b == LPAREN_CHAR || b == DOLLAR_CHAR || b == RPAREN_CHAR) begin
        sj_h1   = b;
        sj_held = HELD_TWO;
      end else begin
        sj_held = HELD_NONE;
        convert_plain(p0);
        take_byte(b);
      end
    end else if (sj_held == HELD_TWO) begin
      sj_held = HELD_NONE;
      if (p1 == LPAREN_CHAR && (b == B_CHAR || b == J_CHAR)) begin
        sj_mode = MODE_ASCII;
      end else if (p1 == LPAREN_CHAR && b == I_CHAR) begin
        sj_mode = MODE_KANA;
      end else if (p1 == DOLLAR_CHAR && (b == AT_CHAR || b == B_CHAR)) begin
        sj_mode = MODE_DOUBLE;
      end else if (p1 == RPAREN_CHAR && b == I_CHAR) begin
        sj_mode = MODE_ASCII;
      end else begin
        convert_plain(p0);
        convert_plain(p1);
        take_byte(b);
      end
    end else begin
      sj_held = HELD_NONE;
      take_byte(b);
    end
    if (last) begin
      if (sj_held == HELD_ONE || sj_held == HELD_TWO) begin
        cnt = sj_held;
        p0 = sj_h0;
        p1 = sj_h1;
        sj_held = HELD_NONE;
        convert_plain(p0);
        if (cnt == HELD_TWO) begin
          convert_plain(p1);
        end
      end
      sj_mode = MODE_ASCII;
      sj_held = HELD_NONE;
      sj_h0   = 8'h00;
      sj_h1   = 8'h00;
      sj_pair = 1'b0;
    end
    if (step_n > 0) begin
      step_bytes[step_n-1].last = 1'b1;
    end
    for (int i = 0; i < step_n; i++) begin
      exp_buf[exp_wr % EXP_DEPTH] = step_bytes[i];
      exp_wr++;
    end
  endtask

  always @(posedge clk) begin
    sjis_byte_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_sjis(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (exp_wr == exp_rd) begin
          report_mismatch("unexpected item", out_tdata, 0);
        end else begin
          want = exp_buf[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_tdata !== want.data) report_mismatch("out_byte", out_tdata, want.data);
          if (out_tuser !== want.bad) report_mismatch("bad_pair", out_tuser, want.bad);
          if (out_tlast !== want.last) report_mismatch("out_last", out_tlast, want.last);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("iso2022jp_to_shift_jis_top regression: fail");
          $finish;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 14);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_escape(input logic [7:0] b1, input logic [7:0] b2);
    send_byte(ESC_CHAR, 1'b0);
    send_byte(b1, 1'b0);
    send_byte(b2, 1'b0);
  endtask

  task automatic test_single_byte_modes();
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_escape(LPAREN_CHAR, I_CHAR);
    send_byte(8'h31, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_escape(RPAREN_CHAR, I_CHAR);
    send_byte(8'h7F, 1'b0);
  endtask

  task automatic test_double_byte();
    send_escape(DOLLAR_CHAR, B_CHAR);
    send_byte(8'h21, 1'b0);
    send_byte(8'h60, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h31, 1'b0);
    send_byte(ESC_CHAR, 1'b0);
    send_escape(LPAREN_CHAR, J_CHAR);
  endtask

  task automatic test_end_of_string();
    send_byte(ESC_CHAR, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_escape(DOLLAR_CHAR, AT_CHAR);
    send_byte(8'h30, 1'b1);
    send_byte(ESC_CHAR, 1'b0);
    send_byte(LPAREN_CHAR, 1'b0);
    send_byte(ESC_CHAR, 1'b1);
  endtask

  task automatic test_random_stream(input int n_items);
    int         start;
    int         sel;
    int         run;
    logic [1:0] gen_mode;
    logic       last;
    logic [7:0] b;
    start    = items_sent;
    gen_mode = MODE_ASCII;
    while (items_sent - start < n_items) begin
      quiet = (items_sent - start) >= (n_items - QUIET_TAIL);
      sel   = $urandom_range(0, 9);
      if (sel <= 2) begin
        case ($urandom_range(0, 5))
          0: begin send_escape(LPAREN_CHAR, B_CHAR); gen_mode = MODE_ASCII; end
          1: begin send_escape(LPAREN_CHAR, J_CHAR); gen_mode = MODE_ASCII; end
          2: begin send_escape(RPAREN_CHAR, I_CHAR); gen_mode = MODE_ASCII; end
          3: begin send_escape(LPAREN_CHAR, I_CHAR); gen_mode = MODE_KANA; end
          4: begin send_escape(DOLLAR_CHAR, AT_CHAR); gen_mode = MODE_DOUBLE; end
          default: begin send_escape(DOLLAR_CHAR, B_CHAR); gen_mode = MODE_DOUBLE; end
        endcase
      end else if (sel <= 7) begin
        run = $urandom_range(1, 8);
        for (int i = 0; i < run; i++) begin
          if (gen_mode == MODE_DOUBLE && $urandom_range(0, 9) != 0) begin
            b = 8'($urandom_range(JIS_LOW, JIS_HIGH));
          end else begin
            b = 8'($urandom_range(0, 255));
          end
          if (gen_mode == MODE_DOUBLE) begin
            send_byte(b, 1'b0);
            b = 8'($urandom_range(JIS_LOW, JIS_HIGH));
          end
          last = ($urandom_range(0, 24) == 0);
          send_byte(b, last);
          if (last) gen_mode = MODE_ASCII;
        end
      end else if (sel == 8) begin
        send_byte(ESC_CHAR, 1'b0);
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 2))
            0: send_byte(LPAREN_CHAR, 1'b0);
            1: send_byte(DOLLAR_CHAR, 1'b0);
            default: send_byte(RPAREN_CHAR, 1'b0);
          endcase
        end
        b = ($urandom_range(0, 3) == 0) ? ESC_CHAR : 8'($urandom_range(0, 255));
        last = ($urandom_range(0, 3) == 0);
        send_byte(b, last);
        if (last) gen_mode = MODE_ASCII;
      end else begin
        last = ($urandom_range(0, 9) == 0);
        send_byte(8'($urandom_range(0, 255)), last);
        if (last) gen_mode = MODE_ASCII;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_byte_modes();
    test_double_byte();
    test_end_of_string();
    test_random_stream(RANDOM_ITEMS);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("iso2022jp_to_shift_jis_top regression: pass");
    end else begin
      $display("iso2022jp_to_shift_jis_top regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/iso2sj_pkg.sv
rtl/core/iso2sj_decode.sv
rtl/core/iso2sj_obuf.sv
rtl/core/iso2022jp_to_shift_jis_top.sv
tb/testbench.sv
